>>> rtl/core/cbbpf_pkg.sv
`timescale 1ns / 1ps

package cbbpf_pkg;

    localparam int MAX_ROWS_DEF = 2048;

    localparam int RADIUS_W = 6;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd20;

    localparam int LUMA_W  = 8;
    localparam int ROW_W   = 11;
    localparam int POS_W   = 17;
    localparam int FRAC_W  = 16;
    // window holds at most 2*63+1 rows, sum of 127 bytes
    localparam int WIN_W   = 7;
    localparam int SUM_W   = 15;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    typedef struct packed {
        logic [ROW_W-1:0] first;
        logic [ROW_W-1:0] last;
        logic [POS_W-1:0] pos;
        logic             single;
        logic             ovf;
    } t_result;

    // row address bits
    function automatic int f_aw(input int max_rows);
        return $clog2(max_rows);
    endfunction

    // row count bits, holds max_rows itself
    function automatic int f_cw(input int max_rows);
        return $clog2(max_rows + 1);
    endfunction

    // (first+last) << 16
    function automatic int f_num_w(input int max_rows);
        return f_aw(max_rows) + 1 + FRAC_W;
    endfunction

    // either 2*(rows-1) or the window row count
    function automatic int f_den_w(input int max_rows);
        return (f_cw(max_rows) + 1 > WIN_W) ? f_cw(max_rows) + 1 : WIN_W;
    endfunction

endpackage

>>> rtl/core/cbbpf_store.sv
`timescale 1ns / 1ps

module cbbpf_store #(
    parameter int DEPTH = cbbpf_pkg::MAX_ROWS_DEF,
    parameter int AW    = cbbpf_pkg::f_aw(cbbpf_pkg::MAX_ROWS_DEF)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [cbbpf_pkg::LUMA_W-1:0]  i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [cbbpf_pkg::LUMA_W-1:0]  o_rdata
);

    logic [cbbpf_pkg::LUMA_W-1:0] r_mem [DEPTH];
    logic [cbbpf_pkg::LUMA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/cbbpf_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module cbbpf_div #(
    parameter int NUM_W = cbbpf_pkg::f_num_w(cbbpf_pkg::MAX_ROWS_DEF),
    parameter int DEN_W = cbbpf_pkg::f_den_w(cbbpf_pkg::MAX_ROWS_DEF)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int SW = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [SW-1:0]    r_step;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};
        // without a subtract the partial remainder is below the divisor
        n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quo  <= {r_quo[NUM_W-2:0], fits};
                r_step <= r_step + 1'b1;
                if (r_step == SW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/core/cbbpf_seq.sv
`timescale 1ns / 1ps

// Frame capture and sliding window sequencer with peak tracking.
module cbbpf_seq #(
    parameter int MAX_ROWS = cbbpf_pkg::MAX_ROWS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [cbbpf_pkg::RADIUS_W-1:0]         i_radius,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [cbbpf_pkg::LUMA_W-1:0]           i_in_luma,
    input  logic                                   i_in_last,
    output logic                                   o_mem_we,
    output logic [cbbpf_pkg::f_aw(MAX_ROWS)-1:0]   o_mem_waddr,
    output logic [cbbpf_pkg::LUMA_W-1:0]           o_mem_wdata,
    output logic [cbbpf_pkg::f_aw(MAX_ROWS)-1:0]   o_mem_raddr,
    input  logic [cbbpf_pkg::LUMA_W-1:0]           i_mem_rdata,
    output logic                                   o_div_start,
    output logic [cbbpf_pkg::f_num_w(MAX_ROWS)-1:0] o_div_num,
    output logic [cbbpf_pkg::f_den_w(MAX_ROWS)-1:0] o_div_den,
    input  logic                                   i_div_done,
    input  logic [cbbpf_pkg::f_num_w(MAX_ROWS)-1:0] i_div_quo,
    input  logic                                   i_out_free,
    output logic                                   o_res_load,
    output cbbpf_pkg::t_result                     o_res
);

    localparam int AW    = cbbpf_pkg::f_aw(MAX_ROWS);
    localparam int CW    = cbbpf_pkg::f_cw(MAX_ROWS);
    localparam int NUM_W = cbbpf_pkg::f_num_w(MAX_ROWS);
    localparam int DEN_W = cbbpf_pkg::f_den_w(MAX_ROWS);
    localparam int XW    = ((CW > cbbpf_pkg::RADIUS_W) ? CW : cbbpf_pkg::RADIUS_W) + 1;
    localparam int SUM_W = cbbpf_pkg::SUM_W;
    localparam int LW    = cbbpf_pkg::LUMA_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_PRE_ACC,
        S_ADD,
        S_ADD_ACC,
        S_SUB,
        S_SUB_ACC,
        S_DIV,
        S_WAIT,
        S_POS,
        S_POS_WAIT,
        S_OUT
    } t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_cnt;
    logic                         r_ovf;
    logic [AW-1:0]                r_y;
    logic [SUM_W-1:0]             r_sum;
    logic [LW-1:0]                r_best;
    logic [AW-1:0]                r_first;
    logic [AW-1:0]                r_last;
    logic [cbbpf_pkg::POS_W-1:0]  r_pos;

    logic          accept;
    logic          full;
    logic [XW-1:0] rad_x, y_x, bottom_x, hi0_x, up_x, dn_x, lo_x, hi_x, win_x;
    logic          add_ok, sub_ok;
    logic [AW:0]   pair;
    logic [LW-1:0] avg;

    always_comb begin
        accept   = i_in_valid && (r_state == S_IDLE);
        full     = r_cnt == CW'(MAX_ROWS);
        rad_x    = XW'(i_radius);
        y_x      = XW'(r_y);
        bottom_x = XW'(r_cnt) - 1'b1;
        hi0_x    = (rad_x < bottom_x) ? rad_x : bottom_x;
        up_x     = y_x + rad_x;
        add_ok   = up_x <= bottom_x;
        sub_ok   = y_x > rad_x;
        dn_x     = y_x - rad_x - 1'b1;
        lo_x     = sub_ok ? y_x - rad_x : '0;
        hi_x     = add_ok ? up_x : bottom_x;
        win_x    = hi_x - lo_x + 1'b1;
        pair     = (AW + 1)'(r_first) + (AW + 1)'(r_last);
        avg      = i_div_quo[LW-1:0];
    end

    always_comb begin
        case (r_state)
            S_ADD:   o_mem_raddr = up_x[AW-1:0];
            S_SUB:   o_mem_raddr = dn_x[AW-1:0];
            default: o_mem_raddr = r_y;
        endcase
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_mem_we    = accept && !full;
    assign o_mem_waddr = r_cnt[AW-1:0];
    assign o_mem_wdata = i_in_luma;

    assign o_div_start = (r_state == S_DIV) || (r_state == S_POS && r_cnt > CW'(1));
    assign o_div_num   = (r_state == S_POS) ? {pair, {cbbpf_pkg::FRAC_W{1'b0}}}
                                            : NUM_W'(r_sum);
    assign o_div_den   = (r_state == S_POS) ? DEN_W'({r_cnt - 1'b1, 1'b0})
                                            : DEN_W'(win_x);

    assign o_res_load   = (r_state == S_OUT) && i_out_free;
    assign o_res.first  = cbbpf_pkg::ROW_W'(r_first);
    assign o_res.last   = cbbpf_pkg::ROW_W'(r_last);
    assign o_res.pos    = r_pos;
    assign o_res.single = r_cnt == CW'(1);
    assign o_res.ovf    = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!full) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_last) begin
                            r_y     <= '0;
                            r_sum   <= '0;
                            r_state <= S_PRE;
                        end
                    end
                end
                // fill the window of row 0: rows 0 up to min(radius, rows-1)
                S_PRE: begin
                    r_state <= S_PRE_ACC;
                end
                S_PRE_ACC: begin
                    r_sum <= r_sum + SUM_W'(i_mem_rdata);
                    if (y_x == hi0_x) begin
                        r_y     <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_y     <= r_y + 1'b1;
                        r_state <= S_PRE;
                    end
                end
                S_ADD: begin
                    r_state <= S_ADD_ACC;
                end
                S_ADD_ACC: begin
                    if (add_ok) begin
                        r_sum <= r_sum + SUM_W'(i_mem_rdata);
                    end
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_state <= S_SUB_ACC;
                end
                S_SUB_ACC: begin
                    if (sub_ok) begin
                        r_sum <= r_sum - SUM_W'(i_mem_rdata);
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_div_done) begin
                        // row 0 always opens the run, even at zero
                        if (r_y == '0 || avg > r_best) begin
                            r_best  <= avg;
                            r_first <= r_y;
                            r_last  <= r_y;
                        end else if (avg == r_best &&
                                     (AW + 1)'(r_last) + 1'b1 == (AW + 1)'(r_y)) begin
                            r_last <= r_y;
                        end
                        if (y_x == bottom_x) begin
                            r_state <= S_POS;
                        end else begin
                            r_y     <= r_y + 1'b1;
                            r_state <= S_ADD;
                        end
                    end
                end
                S_POS: begin
                    if (r_cnt > CW'(1)) begin
                        r_state <= S_POS_WAIT;
                    end else begin
                        r_pos   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_POS_WAIT: begin
                    if (i_div_done) begin
                        r_pos   <= i_div_quo[cbbpf_pkg::POS_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_free) begin
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/column_box_blur_peak_finder_unit.sv
`timescale 1ns / 1ps
// channel   dir  width  contents (lowest bit first)
// s_axis    in   8+1    tdata: luma[7:0]; tlast: last row of frame
// m_axis    out  40+2   tdata: first row[10:0], last row[21:11], position_q16[38:22], pad
//                       tuser: single_row[0], overflow[1]
// cfg       in   6      window radius, written when i_cfg_wr_en is high
//
// Capture takes one row per cycle; the frame end request blocks input while the
// sliding sum runs: the window of row 0 is filled, then each row adds its new
// bottom row, drops the row that left the top and runs the bit-serial divider
// (NUM_W = clog2(MAX_ROWS)+17 bits) for its average, then the position divide if rows > 1.
// Reset is synchronous, active low; the column store is not cleared.
// A held result waits in the output register; capture of the next frame continues.
// A finished result that finds the output register still held keeps input blocked.

module column_box_blur_peak_finder_unit #(
    parameter int MAX_ROWS = cbbpf_pkg::MAX_ROWS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [cbbpf_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // luma
    input  logic                                 i_s_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [cbbpf_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,  // first, last, position
    output logic [cbbpf_pkg::OUT_USER_W-1:0]     o_m_axis_tuser,  // single_row, overflow
    input  logic                                 i_cfg_wr_en,
    input  logic [cbbpf_pkg::RADIUS_W-1:0]       i_cfg_wr_data
);

    localparam int AW    = cbbpf_pkg::f_aw(MAX_ROWS);
    localparam int NUM_W = cbbpf_pkg::f_num_w(MAX_ROWS);
    localparam int DEN_W = cbbpf_pkg::f_den_w(MAX_ROWS);

    logic [cbbpf_pkg::RADIUS_W-1:0] r_radius;
    logic                           r_ovalid;
    cbbpf_pkg::t_result             r_res;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [cbbpf_pkg::LUMA_W-1:0]   mem_wdata;
    logic [AW-1:0]                  mem_raddr;
    logic [cbbpf_pkg::LUMA_W-1:0]   mem_rdata;
    logic                           div_start;
    logic [NUM_W-1:0]               div_num;
    logic [DEN_W-1:0]               div_den;
    logic                           div_done;
    logic [NUM_W-1:0]               div_quo;
    logic                           out_free;
    logic                           res_load;
    cbbpf_pkg::t_result             res;

    assign out_free = !r_ovalid || i_m_axis_tready;

    cbbpf_store #(
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cbbpf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    cbbpf_seq #(
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radius    (r_radius),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_luma   (i_s_axis_tdata[cbbpf_pkg::LUMA_W-1:0]),
        .i_in_last   (i_s_axis_tlast),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_div_start (div_start),
        .o_div_num   (div_num),
        .o_div_den   (div_den),
        .i_div_done  (div_done),
        .i_div_quo   (div_quo),
        .i_out_free  (out_free),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= cbbpf_pkg::RADIUS_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_radius <= i_cfg_wr_data;
            end
            if (res_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = cbbpf_pkg::OUT_DATA_W'({r_res.pos, r_res.last, r_res.first});
    assign o_m_axis_tuser  = {r_res.ovf, r_res.single};

endmodule

>>> rtl/core/cbbpf_checker.sv
`timescale 1ns / 1ps

module cbbpf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              i_s_axis_tlast,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [cbbpf_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic [cbbpf_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);

    localparam int RW   = cbbpf_pkg::ROW_W;
    localparam int PW   = cbbpf_pkg::POS_W;
    localparam int P_LO = 2 * RW;
    localparam int P_HI = 2 * RW + PW - 1;
    localparam logic [PW-1:0] POS_ONE = PW'(1) << cbbpf_pkg::FRAC_W;

    // held result must not change under back-pressure
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // frame end request starts computation, input closes next cycle
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input still open after frame end");

    // midpoint never exceeds 1.0 and the pad bits stay clear
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[P_HI:P_LO] <= POS_ONE &&
            o_m_axis_tdata[cbbpf_pkg::OUT_DATA_W-1:P_HI+1] == '0)
        else $error("position out of range");

    // single row frame: everything points at row 0
    a_single_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[P_HI:P_LO] == '0 && o_m_axis_tdata[P_LO-1:0] == '0)
        else $error("single row result not at row 0");

endmodule

bind column_box_blur_peak_finder_unit cbbpf_checker u_cbbpf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> verif/tb_column_box_blur_peak_finder_unit.sv
`timescale 1ns / 1ps

module tb_column_box_blur_peak_finder_unit;

    localparam int MAX_ROWS    = cbbpf_pkg::MAX_ROWS_DEF;
    localparam int RAD_W       = cbbpf_pkg::RADIUS_W;
    localparam int QUIET_LIMIT = 300000;
    localparam int RAND_ROWS   = 250;
    localparam int CALM_FROM   = 180;    // no idling after this many random rows

    typedef enum logic {STEP_ROW, STEP_RADIUS} t_step_kind;
    typedef enum logic [2:0] {
        LOOK_NOISE, LOOK_FLAT, LOOK_DARK, LOOK_RAMP, LOOK_STEPS, LOOK_BUMP
    } t_frame_look;

    typedef struct {
        t_step_kind         kind;
        logic [7:0]         value;   // luma, or the radius for STEP_RADIUS
        logic               last;
        bit                 typed;   // peak below is the expected result
        cbbpf_pkg::t_result peak;
    } t_plan_step;

    localparam cbbpf_pkg::t_result NO_PEAK = '0;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_s_axis_tvalid;
    logic                                o_s_axis_tready;
    logic [cbbpf_pkg::IN_DATA_W-1:0]     i_s_axis_tdata;   // luma[7:0]
    logic                                i_s_axis_tlast;   // last row of frame
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready;
    logic [cbbpf_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata;   // first[10:0], last[21:11],
                                                           // position[38:22]
    logic [cbbpf_pkg::OUT_USER_W-1:0]    o_m_axis_tuser;   // single_row[0], overflow[1]
    logic                                i_cfg_wr_en;
    logic [RAD_W-1:0]                    i_cfg_wr_data;

    column_box_blur_peak_finder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    // frame model
    logic [cbbpf_pkg::LUMA_W-1:0] luma_store [MAX_ROWS];
    int                           frame_len;
    bit                           frame_dropped;
    logic [RAD_W-1:0]             radius_model;

    cbbpf_pkg::t_result pending_peaks [$];
    int                 mismatches;
    int                 quiet_cycles;
    int                 stall_left;
    int                 rand_rows;
    bit                 idling;
    t_plan_step         directed_plan [26];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // brightest smoothed plateau over the rows held in luma_store
    function automatic cbbpf_pkg::t_result locate_peak(input int rows, input int radius,
                                                       input bit dropped);
        cbbpf_pkg::t_result r;
        int                 y, z, lo, hi, sum, avg, best, first, last;
        bit                 have;
        longint             span;
        r = '0;
        best = 0;
        first = 0;
        last = 0;
        have = 1'b0;
        for (y = 0; y < rows; y++) begin
            lo = (y > radius) ? y - radius : 0;
            hi = y + radius;
            if (hi > rows - 1) hi = rows - 1;
            sum = 0;
            for (z = lo; z <= hi; z++) sum += luma_store[z];
            avg = sum / (hi - lo + 1);
            // row 0 always opens a run, so an all-dark column gives the top plateau
            if (avg > best || (!have && avg == best && y == 0)) begin
                best = avg;
                first = y;
                last = y;
                have = 1'b1;
            end else if (have && avg == best && y == last + 1) begin
                last = y;
            end
        end
        r.first = first[cbbpf_pkg::ROW_W-1:0];
        r.last = last[cbbpf_pkg::ROW_W-1:0];
        if (rows > 1) begin
            span = (longint'(first + last) << cbbpf_pkg::FRAC_W) / (2 * longint'(rows - 1));
            r.pos = span[cbbpf_pkg::POS_W-1:0];
        end
        r.single = (rows == 1);
        r.ovf = dropped;
        return r;
    endfunction

    task automatic push_row(input logic [7:0] luma, input logic last, input bit typed,
                            input cbbpf_pkg::t_result peak);
        cbbpf_pkg::t_result want;
        if (idling && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= luma;
        i_s_axis_tlast <= last;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        if (frame_len < MAX_ROWS) begin
            luma_store[frame_len] = luma;
            frame_len++;
        end else begin
            frame_dropped = 1'b1;
        end
        if (last) begin
            want = locate_peak(frame_len, radius_model, frame_dropped);
            pending_peaks.push_back(typed ? peak : want);
            frame_len = 0;
            frame_dropped = 1'b0;
        end
    endtask

    // stop sending and let every result come out
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_peaks.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic set_radius(input logic [RAD_W-1:0] radius);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= radius;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        radius_model = radius;
    endtask

    task automatic send_frame(input int len);
        t_frame_look look;
        int          y, v, base, slope, centre, level, gap;
        look = t_frame_look'($urandom_range(0, 5));
        base = $urandom_range(0, 255);
        slope = $urandom_range(0, 18) - 9;
        centre = $urandom_range(0, len - 1);
        level = $urandom_range(1, 120);
        for (y = 0; y < len; y++) begin
            case (look)
                LOOK_NOISE: v = $urandom_range(0, 255);
                LOOK_FLAT:  v = base;
                LOOK_DARK:  v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 0;
                LOOK_RAMP:  v = (base + y * slope) & 8'hFF;
                LOOK_STEPS: v = $urandom_range(0, 2) * level;
                default: begin
                    gap = (y > centre) ? y - centre : centre - y;
                    v = 255 - gap * (slope + 10);
                    if (v < 0) v = 0;
                end
            endcase
            push_row(v[7:0], y == len - 1, 1'b0, NO_PEAK);
            rand_rows++;
        end
    endtask

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left == 0 && idling && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        cbbpf_pkg::t_result got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.first = o_m_axis_tdata[10:0];
            got.last = o_m_axis_tdata[21:11];
            got.pos = o_m_axis_tdata[38:22];
            got.single = o_m_axis_tuser[0];
            got.ovf = o_m_axis_tuser[1];
            if (pending_peaks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result with none pending, first %0d last %0d",
                             got.first, got.last);
            end else begin
                want = pending_peaks.pop_front();
                compare_field("peak_first_row", want.first, got.first);
                compare_field("peak_last_row", want.last, got.last);
                compare_field("position_q16", want.pos, got.pos);
                compare_field("single_row", want.single, got.single);
                compare_field("overflow", want.ovf, got.ovf);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("column_box_blur_peak_finder_unit regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int i, len, pick, frames;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tlast <= 1'b0;
        i_m_axis_tready <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        frame_len = 0;
        frame_dropped = 1'b0;
        radius_model = cbbpf_pkg::RADIUS_RST;
        mismatches = 0;
        quiet_cycles = 0;
        stall_left = 0;
        rand_rows = 0;
        idling = 1'b1;

        directed_plan = '{
            // single row frames, bright and dark
            '{STEP_ROW, 8'd255, 1'b1, 1'b1, '{11'd0, 11'd0, 17'd0, 1'b1, 1'b0}},
            '{STEP_ROW, 8'd0,   1'b1, 1'b1, '{11'd0, 11'd0, 17'd0, 1'b1, 1'b0}},
            // all dark: zero plateau from the top
            '{STEP_ROW, 8'd0,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd0,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd0,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd0,   1'b1, 1'b1, '{11'd0, 11'd3, 17'd32768, 1'b0, 1'b0}},
            '{STEP_ROW, 8'd0,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd255, 1'b1, 1'b1, '{11'd0, 11'd1, 17'd32768, 1'b0, 1'b0}},
            '{STEP_RADIUS, 8'd0, 1'b0, 1'b0, NO_PEAK},
            // a later run at the same level is ignored
            '{STEP_ROW, 8'd5,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd9,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd3,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd9,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd9,   1'b1, 1'b1, '{11'd1, 11'd1, 17'd16384, 1'b0, 1'b0}},
            // a strictly brighter run takes over
            '{STEP_ROW, 8'd7,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd7,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd200, 1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd200, 1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd1,   1'b1, 1'b1, '{11'd2, 11'd3, 17'd40960, 1'b0, 1'b0}},
            '{STEP_RADIUS, 8'd63, 1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd255, 1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd255, 1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd255, 1'b1, 1'b1, '{11'd0, 11'd2, 17'd32768, 1'b0, 1'b0}},
            '{STEP_ROW, 8'd0,   1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd128, 1'b0, 1'b0, NO_PEAK},
            '{STEP_ROW, 8'd7,   1'b1, 1'b0, NO_PEAK}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == STEP_RADIUS) begin
                settle();
                set_radius(directed_plan[k].value[RAD_W-1:0]);
            end else begin
                push_row(directed_plan[k].value, directed_plan[k].last,
                         directed_plan[k].typed, directed_plan[k].peak);
            end
        end

        // full column, peak on the bottom row, then rows past capacity are dropped
        settle();
        set_radius('0);
        for (i = 0; i < MAX_ROWS; i++)
            push_row((i == MAX_ROWS - 1) ? 8'd255 : 8'd0, 1'b0, 1'b0, NO_PEAK);
        for (i = 0; i < 3; i++)
            push_row(8'($urandom_range(0, 255)), i == 2, 1'b0, NO_PEAK);

        while (rand_rows < RAND_ROWS) begin
            settle();
            pick = $urandom_range(0, 3);
            case (pick)
                0:       set_radius('0);
                1:       set_radius('1);
                default: set_radius(RAD_W'($urandom_range(0, 63)));
            endcase
            idling = (rand_rows < CALM_FROM) && ($urandom_range(0, 3) != 0);
            frames = $urandom_range(2, 8);
            repeat (frames) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) len = $urandom_range(1, 24);
                else if (pick < 97) len = $urandom_range(25, 120);
                else len = $urandom_range(121, 400);
                send_frame(len);
            end
        end

        settle();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_peaks.size() == 0) begin
            $display("column_box_blur_peak_finder_unit regression: pass");
        end else begin
            $display("column_box_blur_peak_finder_unit regression: fail");
        end
        $finish;
    end

endmodule
